// ===== sv/lid_pkg.sv =====
package lid_pkg;

    // default geometry of the coordinates and of the fixed-point result
    localparam int LID_COORD_WIDTH   = 16;
    localparam int LID_FRACTION_BITS = 8;

    // result coordinate width and quotient cap (2^40)
    localparam int LID_OUT_WIDTH = 32;
    localparam int LID_CAP_LOG2  = 40;
    localparam int LID_QUO_WIDTH = LID_CAP_LOG2 + 1;

    // control that travels with each pipeline slot
    typedef struct packed {
        logic valid;
        logic parallel;
    } t_lid_ctl;

endpackage

// ===== sv/lid_if.sv =====
interface lid_line_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

interface lid_cross_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic               parallel;
    logic               clipped;

    modport source (
        output valid, cross_x, cross_y, parallel, clipped,
        input  ready
    );
    modport sink (
        input  valid, cross_x, cross_y, parallel, clipped,
        output ready
    );
endinterface

// ===== sv/lid_div_stage.sv =====
module lid_div_stage
    import lid_pkg::*;
#(
    parameter int PW = 35,
    parameter int NW = 60,
    parameter int SW = 34
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_lid_ctl                i_ctl,
    input  logic [PW-1:0]           i_dm,
    input  logic [SW-1:0]           i_side,
    input  logic [1:0][PW-1:0]      i_rem,
    input  logic [1:0][NW-1:0]      i_dvd,
    input  logic [1:0][LID_QUO_WIDTH-1:0] i_quo,
    input  logic [1:0]              i_ovf,
    output t_lid_ctl                o_ctl,
    output logic [PW-1:0]           o_dm,
    output logic [SW-1:0]           o_side,
    output logic [1:0][PW-1:0]      o_rem,
    output logic [1:0][NW-1:0]      o_dvd,
    output logic [1:0][LID_QUO_WIDTH-1:0] o_quo,
    output logic [1:0]              o_ovf
);

    logic [1:0][PW:0]               w_trial;
    logic [1:0][PW:0]               w_diff;
    logic [1:0]                     w_bit;
    logic [1:0][PW-1:0]             n_rem;

    // one restoring step per axis: bring down the next dividend bit
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_trial[a] = {i_rem[a], i_dvd[a][NW-1]};
            w_diff[a]  = w_trial[a] - {1'b0, i_dm};
            w_bit[a]   = (w_trial[a] >= {1'b0, i_dm});
            n_rem[a]   = w_bit[a] ? w_diff[a][PW-1:0] : w_trial[a][PW-1:0];
        end
    end

    // hold control under stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    // advance the partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dm   <= i_dm;
            o_side <= i_side;
            for (int a = 0; a < 2; a++) begin
                o_rem[a] <= n_rem[a];
                o_dvd[a] <= {i_dvd[a][NW-2:0], 1'b0};
                o_quo[a] <= {i_quo[a][LID_QUO_WIDTH-2:0], w_bit[a]};
                o_ovf[a] <= i_ovf[a] | i_quo[a][LID_QUO_WIDTH-1];
            end
        end
    end

endmodule

// ===== sv/line_intersection_2d_unit.sv =====
// Intersection of two infinite 2D lines, fully pipelined.
// Channel i_line carries two lines as start/end points, signed integers of
// COORD_WIDTH bits. Channel o_cross returns the crossing point as signed
// 32-bit fixed point with FRACTION_BITS fraction bits, plus a parallel flag
// (zero determinant: coordinates zero) and a clipped flag (a coordinate
// saturated to the 32-bit range).
// Throughput: one transfer per cycle while the receiver takes results.
// The dividend width is NW = 3*COORD_WIDTH + 4 + FRACTION_BITS; each bit of
// it takes one restoring divider stage.
// The front end takes four register stages: differences, the cross
// products, numerator and determinant, the numerator times direction
// product. A last stage adds the start point and saturates.
// Reset clears every valid bit; payload registers are not reset.
// When the receiver stalls, the whole pipeline holds; i_line.ready is low
// only while a finished result waits at the output and is not taken.
module line_intersection_2d_unit
    import lid_pkg::*;
#(
    parameter int COORD_WIDTH   = LID_COORD_WIDTH,
    parameter int FRACTION_BITS = LID_FRACTION_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lid_line_if.sink    i_line,
    lid_cross_if.source o_cross
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW + 1;
    localparam int NW = PW + DW + FRACTION_BITS;
    localparam int SW = 2 * CW + 2;
    localparam int QW = LID_QUO_WIDTH;
    localparam int OW = LID_OUT_WIDTH;
    localparam int BW = CW + FRACTION_BITS;
    localparam int TW = ((BW > QW) ? BW : QW) + 2;

    logic en;

    // stage 1: differences
    t_lid_ctl              r1_ctl;
    logic signed [DW-1:0]  r1_px, r1_py, r1_rx, r1_ry, r1_sx, r1_sy;
    logic signed [CW-1:0]  r1_ax, r1_ay;

    // stage 2: cross products
    t_lid_ctl                r2_ctl;
    logic signed [2*DW-1:0]  r2_pxsy, r2_pysx, r2_rxsy, r2_rysx;
    logic signed [DW-1:0]    r2_rx, r2_ry;
    logic signed [CW-1:0]    r2_ax, r2_ay;

    // stage 3: numerator, determinant, magnitudes and signs
    t_lid_ctl                r3_ctl;
    logic [PW-1:0]           r3_mnum, r3_mden;
    logic [DW-1:0]           r3_mrx, r3_mry;
    logic                    r3_negx, r3_negy;
    logic signed [CW-1:0]    r3_ax, r3_ay;
    logic signed [PW-1:0]    w_num, w_den;

    // stage 4: dividends
    t_lid_ctl                r4_ctl;
    logic [1:0][NW-1:0]      r4_dvd;
    logic [PW-1:0]           r4_dm;
    logic [SW-1:0]           r4_side;

    // divider chain
    t_lid_ctl                      w_ctl  [0:NW];
    logic [PW-1:0]                 w_dm   [0:NW];
    logic [SW-1:0]                 w_side [0:NW];
    logic [1:0][PW-1:0]            w_rem  [0:NW];
    logic [1:0][NW-1:0]            w_dvd  [0:NW];
    logic [1:0][QW-1:0]            w_quo  [0:NW];
    logic [1:0]                    w_ovf  [0:NW];

    // output stage
    logic                  r_out_valid;
    logic signed [OW-1:0]  r_cross_x, r_cross_y;
    logic                  r_parallel, r_clipped;

    assign en           = !r_out_valid || o_cross.ready;
    assign i_line.ready = en;

    // control flow of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else if (en) begin
            r1_ctl <= '{valid: i_line.valid, parallel: 1'b0};
            r2_ctl <= r1_ctl;
            r3_ctl <= '{valid: r2_ctl.valid, parallel: (w_den == '0)};
            r4_ctl <= r3_ctl;
        end
    end

    // stage 1: direction and offset vectors
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px <= {i_line.b_start_x[CW-1], i_line.b_start_x}
                   - {i_line.a_start_x[CW-1], i_line.a_start_x};
            r1_py <= {i_line.b_start_y[CW-1], i_line.b_start_y}
                   - {i_line.a_start_y[CW-1], i_line.a_start_y};
            r1_rx <= {i_line.a_end_x[CW-1], i_line.a_end_x}
                   - {i_line.a_start_x[CW-1], i_line.a_start_x};
            r1_ry <= {i_line.a_end_y[CW-1], i_line.a_end_y}
                   - {i_line.a_start_y[CW-1], i_line.a_start_y};
            r1_sx <= {i_line.b_end_x[CW-1], i_line.b_end_x}
                   - {i_line.b_start_x[CW-1], i_line.b_start_x};
            r1_sy <= {i_line.b_end_y[CW-1], i_line.b_end_y}
                   - {i_line.b_start_y[CW-1], i_line.b_start_y};
            r1_ax <= i_line.a_start_x;
            r1_ay <= i_line.a_start_y;
        end
    end

    // stage 2: four signed products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pxsy <= r1_px * r1_sy;
            r2_pysx <= r1_py * r1_sx;
            r2_rxsy <= r1_rx * r1_sy;
            r2_rysx <= r1_ry * r1_sx;
            r2_rx   <= r1_rx;
            r2_ry   <= r1_ry;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
        end
    end

    // stage 3: numerator and determinant, split into sign and magnitude
    assign w_num = {r2_pxsy[2*DW-1], r2_pxsy} - {r2_pysx[2*DW-1], r2_pysx};
    assign w_den = {r2_rxsy[2*DW-1], r2_rxsy} - {r2_rysx[2*DW-1], r2_rysx};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mnum <= w_num[PW-1] ? PW'(-w_num) : PW'(w_num);
            r3_mden <= w_den[PW-1] ? PW'(-w_den) : PW'(w_den);
            r3_mrx  <= r2_rx[DW-1] ? DW'(-r2_rx) : DW'(r2_rx);
            r3_mry  <= r2_ry[DW-1] ? DW'(-r2_ry) : DW'(r2_ry);
            r3_negx <= (w_num != '0) && (r2_rx != '0)
                     && (w_num[PW-1] ^ r2_rx[DW-1] ^ w_den[PW-1]);
            r3_negy <= (w_num != '0) && (r2_ry != '0)
                     && (w_num[PW-1] ^ r2_ry[DW-1] ^ w_den[PW-1]);
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
        end
    end

    // stage 4: scaled dividend per axis
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dvd[0] <= (NW'(r3_mnum) * NW'(r3_mrx)) << FRACTION_BITS;
            r4_dvd[1] <= (NW'(r3_mnum) * NW'(r3_mry)) << FRACTION_BITS;
            r4_dm     <= r3_mden;
            r4_side   <= {r3_negy, r3_negx, r3_ay, r3_ax};
        end
    end

    // restoring divider, one quotient bit per stage
    assign w_ctl[0]  = r4_ctl;
    assign w_dm[0]   = r4_dm;
    assign w_side[0] = r4_side;
    assign w_rem[0]  = '0;
    assign w_dvd[0]  = r4_dvd;
    assign w_quo[0]  = '0;
    assign w_ovf[0]  = '0;

    for (genvar k = 0; k < NW; k++) begin : g_div
        lid_div_stage #(
            .PW (PW),
            .NW (NW),
            .SW (SW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (w_ctl[k]),
            .i_dm    (w_dm[k]),
            .i_side  (w_side[k]),
            .i_rem   (w_rem[k]),
            .i_dvd   (w_dvd[k]),
            .i_quo   (w_quo[k]),
            .i_ovf   (w_ovf[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_dm    (w_dm[k+1]),
            .o_side  (w_side[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_dvd   (w_dvd[k+1]),
            .o_quo   (w_quo[k+1]),
            .o_ovf   (w_ovf[k+1])
        );
    end

    // final stage: cap quotient, add start point, saturate
    localparam logic [QW-1:0] QCAP = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [TW-1:0] SAT_MAX = {{(TW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [TW-1:0] SAT_MIN = {{(TW-OW+1){1'b1}}, {(OW-1){1'b0}}};

    logic [1:0][QW-1:0]          w_qc;
    logic signed [1:0][TW-1:0]   w_total;
    logic [1:0]                  w_hi, w_lo;
    logic signed [1:0][OW-1:0]   w_sat;
    logic signed [CW-1:0]        w_start [0:1];
    logic [1:0]                  w_neg;

    always_comb begin
        w_start[0] = w_side[NW][CW-1:0];
        w_start[1] = w_side[NW][2*CW-1:CW];
        w_neg      = w_side[NW][SW-1:SW-2];
        for (int a = 0; a < 2; a++) begin
            w_qc[a] = (w_ovf[NW][a] || (w_quo[NW][a] > QCAP)) ? QCAP : w_quo[NW][a];
            w_total[a] = $signed({{(TW-CW){w_start[a][CW-1]}}, w_start[a]})
                         <<< FRACTION_BITS;
            if (w_neg[a]) begin
                w_total[a] = w_total[a] - $signed({{(TW-QW){1'b0}}, w_qc[a]});
            end else begin
                w_total[a] = w_total[a] + $signed({{(TW-QW){1'b0}}, w_qc[a]});
            end
            w_hi[a] = ($signed(w_total[a]) > SAT_MAX);
            w_lo[a] = ($signed(w_total[a]) < SAT_MIN);
            if (w_hi[a]) begin
                w_sat[a] = SAT_MAX[OW-1:0];
            end else if (w_lo[a]) begin
                w_sat[a] = SAT_MIN[OW-1:0];
            end else begin
                w_sat[a] = w_total[a][OW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_ctl[NW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_parallel <= w_ctl[NW].parallel;
            if (w_ctl[NW].parallel) begin
                r_cross_x <= '0;
                r_cross_y <= '0;
                r_clipped <= 1'b0;
            end else begin
                r_cross_x <= w_sat[0];
                r_cross_y <= w_sat[1];
                r_clipped <= |(w_hi | w_lo);
            end
        end
    end

    assign o_cross.valid    = r_out_valid;
    assign o_cross.cross_x  = r_cross_x;
    assign o_cross.cross_y  = r_cross_y;
    assign o_cross.parallel = r_parallel;
    assign o_cross.clipped  = r_clipped;

    // parallel result carries zero coordinates and no clip
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cross.valid && o_cross.parallel) |->
        (o_cross.cross_x == '0 && o_cross.cross_y == '0 && !o_cross.clipped))
        else $error("parallel result with nonzero fields");

    // a clipped result has a coordinate at a range limit
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cross.valid && o_cross.clipped) |->
        (r_cross_x == SAT_MAX[OW-1:0] || r_cross_x == SAT_MIN[OW-1:0] ||
         r_cross_y == SAT_MAX[OW-1:0] || r_cross_y == SAT_MIN[OW-1:0]))
        else $error("clipped flag without saturated coordinate");

    // a stalled pipeline keeps its first slot
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r1_ctl.valid) |=> r1_ctl.valid)
        else $error("pipeline slot lost under stall");

endmodule

// ===== verif/line_intersection_2d_unit_test.sv =====
`timescale 1ns / 1ps

module line_intersection_2d_unit_test;
    import lid_pkg::*;

    localparam int CW = LID_COORD_WIDTH;
    localparam int FB = LID_FRACTION_BITS;
    localparam int LATENCY = 5 + 3 * CW + 4 + FB;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 360;

    typedef struct packed {
        logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } t_lines;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               par;
        logic               clip;
    } t_cross;

    // directed row: given marks a hand-typed expectation
    typedef struct {
        t_lines ln;
        bit     given;
        t_cross res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    longint cycle_count = 0;
    int errors = 0;
    int n_sent = 0;
    int n_got = 0;
    int n_par = 0;
    int n_clip = 0;
    int src_idle_pct = 21;
    int snk_idle_pct = 56;
    bit hold_sink = 1'b0;

    t_cross crossing_queue[$];

    lid_line_if #(.COORD_WIDTH(CW)) line_ch ();
    lid_cross_if                    cross_ch ();

    line_intersection_2d_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_ch.sink),
        .o_cross (cross_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // truncated quotient of num*r*2^F/den, capped, added to the start point
    function automatic logic signed [31:0] axis_point(
        input longint start, input longint num, input longint r,
        input longint den, inout bit clip
    );
        logic [255:0] prod;
        logic [255:0] quo;
        logic [255:0] dmag;
        logic signed [127:0] total;
        bit neg;
        prod = 256'(num < 0 ? -num : num) * 256'(r < 0 ? -r : r);
        prod = prod << FB;
        dmag = 256'(den < 0 ? -den : den);
        quo = prod / dmag;
        if (quo > (256'(1) << 40)) quo = 256'(1) << 40;
        neg = ((num < 0) != (r < 0)) != (den < 0);
        if (num == 0 || r == 0) neg = 1'b0;
        total = 128'(start) * (128'sd1 <<< FB);
        total = neg ? total - $signed(128'(quo[63:0])) : total + $signed(128'(quo[63:0]));
        if (total > 128'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (total < -128'sd2147483648) begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return total[31:0];
    endfunction

    function automatic t_cross crossing_of(input t_lines l);
        longint px, py, rx, ry, sx, sy, num, den;
        bit clip;
        t_cross c;
        px = longint'(l.bx0) - l.ax0;
        py = longint'(l.by0) - l.ay0;
        rx = longint'(l.ax1) - l.ax0;
        ry = longint'(l.ay1) - l.ay0;
        sx = longint'(l.bx1) - l.bx0;
        sy = longint'(l.by1) - l.by0;
        num = px * sy - py * sx;
        den = rx * sy - ry * sx;
        clip = 1'b0;
        c = '0;
        if (den == 0) begin
            c.par = 1'b1;
            return c;
        end
        c.x = axis_point(l.ax0, num, rx, den, clip);
        c.y = axis_point(l.ay0, num, ry, den, clip);
        c.clip = clip;
        return c;
    endfunction

    function automatic t_lines random_lines();
        t_lines l;
        int mode;
        mode = $urandom_range(0, 9);
        l = {$urandom, $urandom, $urandom, $urandom};
        if (mode < 4) begin
            // small coordinates, from -200 to 200
            l.ax0 = 16'($signed(16'($urandom_range(0, 400))) - 200);
            l.ay0 = 16'($signed(16'($urandom_range(0, 400))) - 200);
            l.ax1 = 16'($signed(16'($urandom_range(0, 400))) - 200);
            l.ay1 = 16'($signed(16'($urandom_range(0, 400))) - 200);
            l.bx0 = 16'($signed(16'($urandom_range(0, 400))) - 200);
            l.by0 = 16'($signed(16'($urandom_range(0, 400))) - 200);
            l.bx1 = 16'($signed(16'($urandom_range(0, 400))) - 200);
            l.by1 = 16'($signed(16'($urandom_range(0, 400))) - 200);
        end else if (mode == 4) begin
            // b is a shifted copy of a's direction (parallel unless the sum wraps)
            l.bx1 = l.bx0 + (l.ax1 - l.ax0);
            l.by1 = l.by0 + (l.ay1 - l.ay0);
        end else if (mode == 5) begin
            l.ax1 = l.ax0;
            l.ay1 = l.ay0;
        end
        return l;
    endfunction

    // drive one transfer, waiting on ready; valid stays up for a following item
    task automatic send_lines(input t_lines l);
        while (($urandom_range(0, 99) < src_idle_pct)) begin
            line_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        line_ch.valid <= 1'b1;
        {line_ch.a_start_x, line_ch.a_start_y, line_ch.a_end_x, line_ch.a_end_y,
         line_ch.b_start_x, line_ch.b_start_y, line_ch.b_end_x, line_ch.b_end_y} <= l;
        @(posedge i_clk);
        while (!line_ch.ready) @(posedge i_clk);
        crossing_queue.push_back(crossing_of(l));
        n_sent++;
        @(negedge i_clk);
    endtask

    // receiver backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sink) cross_ch.ready <= 1'b0;
        else cross_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_cross e;
        if (i_rst_n && cross_ch.valid && cross_ch.ready) begin
            n_got++;
            if (crossing_queue.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = crossing_queue.pop_front();
                if (cross_ch.parallel) n_par++;
                if (cross_ch.clipped) n_clip++;
                if (cross_ch.cross_x !== e.x) begin
                    $error("cross_x expected %0d actual %0d", e.x, cross_ch.cross_x);
                    errors++;
                end
                if (cross_ch.cross_y !== e.y) begin
                    $error("cross_y expected %0d actual %0d", e.y, cross_ch.cross_y);
                    errors++;
                end
                if (cross_ch.parallel !== e.par) begin
                    $error("parallel expected %0b actual %0b", e.par, cross_ch.parallel);
                    errors++;
                end
                if (cross_ch.clipped !== e.clip) begin
                    $error("clipped expected %0b actual %0b", e.clip, cross_ch.clipped);
                    errors++;
                end
            end
        end
    end

    t_row rows[$];

    function automatic t_lines mk(input int a, b, c, d, e, f, g, h);
        t_lines l;
        l = {16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h)};
        return l;
    endfunction

    function automatic t_cross res(input int x, y, input bit p, cl);
        t_cross c;
        c.x = x; c.y = y; c.par = p; c.clip = cl;
        return c;
    endfunction

    task automatic add_row(input t_lines l, input bit g, input t_cross r);
        t_row w;
        w.ln = l; w.given = g; w.res = r;
        rows.push_back(w);
    endtask

    initial begin
        t_cross none;
        none = '0;
        line_ch.valid = 1'b0;
        {line_ch.a_start_x, line_ch.a_start_y, line_ch.a_end_x, line_ch.a_end_y,
         line_ch.b_start_x, line_ch.b_start_y, line_ch.b_end_x, line_ch.b_end_y} = '0;
        cross_ch.ready = 1'b0;

        // all zero: parallel
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 1, 0));
        // axes crossing at the origin
        add_row(mk(-10, 0, 10, 0, 0, -10, 0, 10), 1, res(0, 0, 0, 0));
        // crossing at (5,5)
        add_row(mk(0, 0, 10, 10, 0, 10, 10, 0), 1, res(1280, 1280, 0, 0));
        // parallel horizontal lines
        add_row(mk(0, 0, 10, 0, 0, 5, 10, 5), 1, res(0, 0, 1, 0));
        // coincident lines
        add_row(mk(0, 0, 4, 4, 1, 1, 3, 3), 1, res(0, 0, 1, 0));
        // crossings at (1,0) and (3,-7); the second has a negative y quotient
        add_row(mk(0, 0, 3, 0, 1, -1, 1, 2), 0, none);
        add_row(mk(0, 0, -3, 7, -1, 1, 2, -5), 0, none);
        // extremes: nearly parallel far away, saturation
        add_row(mk(-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32767), 0, none);
        add_row(mk(32767, 32767, -32768, -32768, 32767, 32766, -32768, -32768), 0, none);
        add_row(mk(-32768, 0, -32767, 0, 32767, -32768, 32767, 32767), 0, none);
        add_row(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767), 0, none);
        add_row(mk(-32768, -32768, -32768, -32768, 1, 2, 3, 4), 1, res(0, 0, 1, 0));
        add_row(mk(0, 0, 1, 1, 0, 1, 32767, 1), 0, none);
        add_row(mk(-1, -1, -1, -1, -1, -1, -1, -1), 1, res(0, 0, 1, 0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].given && crossing_of(rows[i].ln) !== rows[i].res) begin
                $error("typed expectation disagrees with prediction in row %0d", i);
                errors++;
            end
            send_lines(rows[i].ln);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 3) begin
                src_idle_pct = 56; snk_idle_pct = 21;
            end
            if (k == 2 * N_RANDOM / 3) begin
                src_idle_pct = 0; snk_idle_pct = 0;
            end
            send_lines(random_lines());
        end

        // hold the receiver while lines keep coming so the pipeline backs up
        fork
            begin
                hold_sink = 1'b1;
                repeat (3 * LATENCY) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            for (int k = 0; k < 2 * LATENCY; k++) send_lines(random_lines());
        join
        line_ch.valid <= 1'b0;

        while (crossing_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Covered %0d line pairs, %0d results: %0d parallel, %0d clipped.",
                 n_sent, n_got, n_par, n_clip);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/lid_pkg.sv
sv/lid_if.sv
sv/lid_div_stage.sv
sv/line_intersection_2d_unit.sv
verif/line_intersection_2d_unit_test.sv
